@@ rtl/crct_pkg.sv @@
package crct_pkg;

  // Default sizes of the table.
  localparam int unsigned TableDepthDef = 32;
  localparam int unsigned KeyBitsDef    = 32;

  // Width of the key fields on the channels.
  localparam int unsigned PortKeyW = 32;

  // Category code that names no record kind.
  localparam logic [1:0] CatInvalid = 2'd3;

  typedef enum logic {
    CMD_APPLY = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_UPD     = 2'd1,
    ACT_DEL     = 2'd2,
    ACT_INVALID = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RK_ACK   = 2'd0,
    RK_ENTRY = 2'd1,
    RK_EMPTY = 2'd2
  } rkind_e;

  // Outcome of the shared pair comparator.
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

@@ rtl/crct_if.sv @@
// Change channel: one beat is one change or one flush request.
interface crct_in_if import crct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [1:0]          category;
  logic [PortKeyW-1:0] item_key;
  logic [1:0]          change_kind;

  modport source (output valid, command, category, item_key, change_kind, input ready);
  modport sink (input valid, command, category, item_key, change_kind, output ready);
endinterface

// Result channel: one beat is one acknowledgement or one emitted entry.
interface crct_out_if import crct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          result_kind;
  logic [1:0]          out_category;
  logic [PortKeyW-1:0] out_key;
  logic [1:0]          out_action;
  logic [1:0]          status;
  logic                last;

  modport source (output valid, result_kind, out_category, out_key, out_action, status, last,
                  input ready);
  modport sink (input valid, result_kind, out_category, out_key, out_action, status, last,
                output ready);
endinterface

@@ rtl/crct_store.sv @@
module crct_store import crct_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned KEY_BITS    = KeyBitsDef,
  localparam int unsigned IdxW       = $clog2(TABLE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_idx_i,
  input  logic [1:0]          wr_cat_i,
  input  logic [KEY_BITS-1:0] wr_key_i,
  input  logic [1:0]          wr_act_i,
  input  logic [IdxW-1:0]     rd_idx_i,
  output logic [1:0]          rd_cat_o,
  output logic [KEY_BITS-1:0] rd_key_o,
  output logic [1:0]          rd_act_o
);

  logic [1:0]          mem_cat [TABLE_DEPTH];
  logic [KEY_BITS-1:0] mem_key [TABLE_DEPTH];
  logic [1:0]          mem_act [TABLE_DEPTH];

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_cat[wr_idx_i] <= wr_cat_i;
      mem_key[wr_idx_i] <= wr_key_i;
      mem_act[wr_idx_i] <= wr_act_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_cat_o <= mem_cat[rd_idx_i];
    rd_key_o <= mem_key[rd_idx_i];
    rd_act_o <= mem_act[rd_idx_i];
  end

endmodule

@@ rtl/crct_cmp.sv @@
module crct_cmp import crct_pkg::*; #(
  parameter int unsigned KEY_BITS = KeyBitsDef
) (
  input  logic [1:0]          a_cat_i,
  input  logic [KEY_BITS-1:0] a_key_i,
  input  logic [1:0]          b_cat_i,
  input  logic [KEY_BITS-1:0] b_key_i,
  output cmp_res_t            res_o
);

  // The category is the more significant part of the pair.
  always_comb begin
    res_o.eq = ({a_cat_i, a_key_i} == {b_cat_i, b_key_i});
    res_o.lt = ({a_cat_i, a_key_i} <  {b_cat_i, b_key_i});
  end

endmodule

@@ rtl/change_record_coalescing_table_unit.sv @@
// Change record coalescing table.
// The in_chan_i channel takes one beat per request: a change (add, update or
// delete of a category and key) or a flush. The out_chan_o channel returns
// one acknowledgement beat per change, carrying its status, and per flush one
// beat per live entry in ascending (category, key) order, or a single beat
// of kind "empty" when the table holds nothing. The last flag marks the
// final beat of each request.
// Every valid change and every flush walks the table with one comparator,
// reading the entries one at a time from the entry memory; a change with an
// invalid code skips the walk, and a flush walks the table anew for each
// emitted entry. One request is worked on at a time, and in_chan_i.ready is
// high only while the block is idle.
// Reset empties the table at once through its valid bits; the entry memory
// itself is not cleared. Results sit in an output register; while the
// receiver holds ready low and that register is full, the sequencer waits
// with its next result and takes no new request.
module change_record_coalescing_table_unit import crct_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned KEY_BITS    = KeyBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crct_in_if.sink    in_chan_i,
  crct_out_if.source out_chan_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TABLE_DEPTH - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_C_RD  = 8'b0000_0010,
    S_C_CMP = 8'b0000_0100,
    S_APPLY = 8'b0000_1000,
    S_F_RD  = 8'b0001_0000,
    S_F_CMP = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_F_END = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0]     idx_q, idx_d;
  logic [1:0]          cat_q, cat_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [1:0]          kind_q, kind_d;

  logic                hit_q, hit_d, free_q, free_d;
  logic [IdxW-1:0]     hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [1:0]          hit_act_q, hit_act_d;

  logic                best_q, best_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic [1:0]          best_cat_q, best_cat_d, best_act_q, best_act_d;
  logic [KEY_BITS-1:0] best_key_q, best_key_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  logic [TABLE_DEPTH-1:0] valid_q, valid_d, done_q, done_d;

  logic [1:0]          pend_kind_q, pend_kind_d, pend_cat_q, pend_cat_d;
  logic [1:0]          pend_act_q, pend_act_d, pend_st_q, pend_st_d;
  logic [PortKeyW-1:0] pend_key_q, pend_key_d;
  logic                pend_last_q, pend_last_d;

  logic                out_vld_q, out_vld_d;
  logic [1:0]          o_kind_q, o_kind_d, o_cat_q, o_cat_d, o_act_q, o_act_d, o_st_q, o_st_d;
  logic [PortKeyW-1:0] o_key_q, o_key_d;
  logic                o_last_q, o_last_d;

  logic                wr_en;
  logic [IdxW-1:0]     wr_idx;
  logic [1:0]          wr_act;
  logic [1:0]          rd_cat, rd_act, b_cat;
  logic [KEY_BITS-1:0] rd_key, b_key;
  cmp_res_t            cmp;
  logic                in_fire, slot_free;

  // Entry memory, read at the scan index.
  crct_store #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS)) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx),
    .wr_cat_i (cat_q),
    .wr_key_i (key_q),
    .wr_act_i (wr_act),
    .rd_idx_i (idx_q),
    .rd_cat_o (rd_cat),
    .rd_key_o (rd_key),
    .rd_act_o (rd_act)
  );

  // The comparator checks the entry read against the request or the best so far.
  assign b_cat = (state_q == S_F_CMP) ? best_cat_q : cat_q;
  assign b_key = (state_q == S_F_CMP) ? best_key_q : key_q;

  crct_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .a_cat_i (rd_cat),
    .a_key_i (rd_key),
    .b_cat_i (b_cat),
    .b_key_i (b_key),
    .res_o   (cmp)
  );

  assign in_chan_i.ready = (state_q == S_IDLE);
  assign in_fire         = in_chan_i.valid && in_chan_i.ready;
  assign slot_free       = !out_vld_q || out_chan_o.ready;

  assign out_chan_o.valid        = out_vld_q;
  assign out_chan_o.result_kind  = o_kind_q;
  assign out_chan_o.out_category = o_cat_q;
  assign out_chan_o.out_key      = o_key_q;
  assign out_chan_o.out_action   = o_act_q;
  assign out_chan_o.status       = o_st_q;
  assign out_chan_o.last         = o_last_q;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cat_d       = cat_q;
    key_d       = key_q;
    kind_d      = kind_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_act_d   = hit_act_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_cat_d  = best_cat_q;
    best_key_d  = best_key_q;
    best_act_d  = best_act_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    done_d      = done_q;
    pend_kind_d = pend_kind_q;
    pend_cat_d  = pend_cat_q;
    pend_key_d  = pend_key_q;
    pend_act_d  = pend_act_q;
    pend_st_d   = pend_st_q;
    pend_last_d = pend_last_q;
    out_vld_d   = out_vld_q && !out_chan_o.ready;
    o_kind_d    = o_kind_q;
    o_cat_d     = o_cat_q;
    o_key_d     = o_key_q;
    o_act_d     = o_act_q;
    o_st_d      = o_st_q;
    o_last_d    = o_last_q;
    wr_en       = 1'b0;
    wr_idx      = free_idx_q;
    wr_act      = kind_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cat_d       = in_chan_i.category;
          key_d       = KEY_BITS'(in_chan_i.item_key);
          kind_d      = in_chan_i.change_kind;
          idx_d       = '0;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          best_d      = 1'b0;
          cnt_d       = '0;
          pend_kind_d = RK_ACK;
          pend_cat_d  = '0;
          pend_key_d  = '0;
          pend_act_d  = '0;
          pend_st_d   = ST_OK;
          pend_last_d = 1'b1;
          if (in_chan_i.command == CMD_FLUSH) begin
            state_d = S_F_RD;
          end else if (in_chan_i.change_kind == ACT_INVALID ||
                       in_chan_i.category == CatInvalid) begin
            pend_st_d = ST_INVALID;
            state_d   = S_EMIT;
          end else begin
            state_d = S_C_RD;
          end
        end
      end
      S_C_RD: state_d = S_C_CMP;
      S_C_CMP: begin
        // Note the matching live entry and the first free slot.
        if (valid_q[idx_q] && cmp.eq && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = idx_q;
          hit_act_d = rd_act;
        end
        if (!valid_q[idx_q] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
        if (idx_q == IdxLast) begin
          state_d = S_APPLY;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_C_RD;
        end
      end
      S_APPLY: begin
        // Merge the change into the table.
        state_d = S_EMIT;
        wr_idx  = hit_idx_q;
        if (!hit_q) begin
          wr_idx = free_idx_q;
          if (!free_q) begin
            pend_st_d = ST_FULL;
          end else begin
            wr_en               = 1'b1;
            valid_d[free_idx_q] = 1'b1;
          end
        end else begin
          unique case (hit_act_q)
            ACT_ADD: begin
              if (kind_q == ACT_ADD) pend_st_d = ST_ILLEGAL;
              else if (kind_q == ACT_DEL) valid_d[hit_idx_q] = 1'b0;
            end
            ACT_UPD: begin
              if (kind_q == ACT_ADD) begin
                pend_st_d = ST_ILLEGAL;
              end else if (kind_q == ACT_DEL) begin
                wr_en  = 1'b1;
                wr_act = ACT_DEL;
              end
            end
            default: begin
              if (kind_q != ACT_ADD) begin
                pend_st_d = ST_ILLEGAL;
              end else begin
                wr_en  = 1'b1;
                wr_act = ACT_UPD;
              end
            end
          endcase
        end
      end
      S_F_RD: state_d = S_F_CMP;
      S_F_CMP: begin
        // Count entries still to emit and keep the smallest pair.
        if (valid_q[idx_q] && !done_q[idx_q]) begin
          cnt_d = cnt_q + 1'b1;
          if (!best_q || cmp.lt) begin
            best_d     = 1'b1;
            best_idx_d = idx_q;
            best_cat_d = rd_cat;
            best_key_d = rd_key;
            best_act_d = rd_act;
          end
        end
        if (idx_q == IdxLast) begin
          state_d = S_F_END;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_F_RD;
        end
      end
      S_F_END: begin
        state_d = S_EMIT;
        if (cnt_q == '0) begin
          pend_kind_d = RK_EMPTY;
          pend_last_d = 1'b1;
        end else begin
          pend_kind_d        = RK_ENTRY;
          pend_cat_d         = best_cat_q;
          pend_key_d         = PortKeyW'(best_key_q);
          pend_act_d         = best_act_q;
          pend_last_d        = (cnt_q == CntW'(1));
          done_d[best_idx_q] = 1'b1;
          if (cnt_q == CntW'(1)) begin
            valid_d = '0;
            done_d  = '0;
          end
        end
      end
      S_EMIT: begin
        // Hand the result to the output register once it is free.
        if (slot_free) begin
          out_vld_d = 1'b1;
          o_kind_d  = pend_kind_q;
          o_cat_d   = pend_cat_q;
          o_key_d   = pend_key_q;
          o_act_d   = pend_act_q;
          o_st_d    = pend_st_q;
          o_last_d  = pend_last_q;
          if (pend_last_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = '0;
            best_d  = 1'b0;
            cnt_d   = '0;
            state_d = S_F_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      done_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      done_q    <= done_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    cat_q       <= cat_d;
    key_q       <= key_d;
    kind_q      <= kind_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    hit_act_q   <= hit_act_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    best_cat_q  <= best_cat_d;
    best_key_q  <= best_key_d;
    best_act_q  <= best_act_d;
    cnt_q       <= cnt_d;
    pend_kind_q <= pend_kind_d;
    pend_cat_q  <= pend_cat_d;
    pend_key_q  <= pend_key_d;
    pend_act_q  <= pend_act_d;
    pend_st_q   <= pend_st_d;
    pend_last_q <= pend_last_d;
    o_kind_q    <= o_kind_d;
    o_cat_q     <= o_cat_d;
    o_key_q     <= o_key_d;
    o_act_q     <= o_act_d;
    o_st_q      <= o_st_d;
    o_last_q    <= o_last_d;
  end

`ifndef SYNTHESIS
  // A new entry only ever lands in a slot that is free.
  a_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY && !hit_q && free_q) |-> !valid_q[free_idx_q])
    else $error("new entry placed over a live entry");

  // No emitted-entry marks survive outside a flush.
  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (done_q == '0))
    else $error("emitted marks left after flush");

  // The last beat of a flush leaves the table empty.
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_F_END && cnt_q == CntW'(1)) |=> (valid_q == '0))
    else $error("table not cleared after flush");

  // A result is loaded only when the output register can take it.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_chan_o.ready) |=> (out_vld_q && $stable(o_key_q)))
    else $error("pending result overwritten");
`endif

endmodule

@@ test/crct_test_if.sv @@
`timescale 1ns / 1ps

// Driver-side helper interface is not needed; channels come from rtl/crct_if.sv.
// This file only holds a small record type shared by the bench.
package crct_test_pkg;
  import crct_pkg::*;

  // One expected result beat.
  typedef struct packed {
    rkind_e              kind;
    logic [1:0]          cat;
    logic [PortKeyW-1:0] key;
    logic [1:0]          act;
    status_e             st;
    logic                last;
  } beat_t;
endpackage

@@ test/change_record_coalescing_table_unit_test.sv @@
`timescale 1ns / 1ps

module change_record_coalescing_table_unit_test;
  import crct_pkg::*;
  import crct_test_pkg::*;

  localparam int Depth = 32;

  // Golden table model and store of pending result beats.
  class coalesce_board;
    bit                  live[Depth];
    logic [1:0]          cat_q[Depth];
    logic [PortKeyW-1:0] key_q[Depth];
    act_e                act_q[Depth];
    beat_t               pending[$];
    int                  errors;

    function status_e merge(logic [1:0] c, logic [PortKeyW-1:0] k, act_e a);
      int hit;
      int slot;
      hit = -1;
      slot = -1;
      if (a == ACT_INVALID || c == CatInvalid) return ST_INVALID;
      for (int i = 0; i < Depth; i++) begin
        if (live[i]) begin
          if (hit < 0 && cat_q[i] == c && key_q[i] == k) hit = i;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (hit < 0) begin
        if (slot < 0) return ST_FULL;
        live[slot] = 1;
        cat_q[slot] = c;
        key_q[slot] = k;
        act_q[slot] = a;
        return ST_OK;
      end
      case (act_q[hit])
        ACT_ADD: begin
          if (a == ACT_ADD) return ST_ILLEGAL;
          if (a == ACT_DEL) live[hit] = 0;
        end
        ACT_UPD: begin
          if (a == ACT_ADD) return ST_ILLEGAL;
          if (a == ACT_DEL) act_q[hit] = ACT_DEL;
        end
        default: begin
          if (a != ACT_ADD) return ST_ILLEGAL;
          act_q[hit] = ACT_UPD;
        end
      endcase
      return ST_OK;
    endfunction

    function int count_live();
      int n;
      n = 0;
      for (int i = 0; i < Depth; i++) n += live[i];
      return n;
    endfunction

    // Note an accepted request and queue the beats it causes.
    function void note_request(logic cmd, logic [1:0] c, logic [PortKeyW-1:0] k,
                               logic [1:0] a);
      beat_t b;
      int n;
      int best;
      b = '0;
      b.last = 1;
      if (cmd == CMD_APPLY) begin
        b.kind = RK_ACK;
        b.st = merge(c, k, act_e'(a));
        pending = {pending, b};
        return;
      end
      n = count_live();
      if (n == 0) begin
        b.kind = RK_EMPTY;
        pending = {pending, b};
        return;
      end
      for (int j = 0; j < n; j++) begin
        best = -1;
        for (int i = 0; i < Depth; i++) begin
          if (live[i] && (best < 0 || cat_q[i] < cat_q[best] ||
              (cat_q[i] == cat_q[best] && key_q[i] < key_q[best]))) best = i;
        end
        b.kind = RK_ENTRY;
        b.cat = cat_q[best];
        b.key = key_q[best];
        b.act = act_q[best];
        b.st = ST_OK;
        b.last = (j == n - 1);
        pending = {pending, b};
        live[best] = 0;
      end
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_beat(beat_t got);
      beat_t exp_b;
      if (pending.size() == 0) begin
        report("unexpected beat", 0, got);
        return;
      end
      exp_b = pending.pop_front();
      if (got.kind !== exp_b.kind) report("result_kind", exp_b.kind, got.kind);
      if (got.cat !== exp_b.cat) report("out_category", exp_b.cat, got.cat);
      if (got.key !== exp_b.key) report("out_key", exp_b.key, got.key);
      if (got.act !== exp_b.act) report("out_action", exp_b.act, got.act);
      if (got.st !== exp_b.st) report("status", exp_b.st, got.st);
      if (got.last !== exp_b.last) report("last", exp_b.last, got.last);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] seen);
      errors++;
      $display("mismatch %s: expected %0h got %0h", what, want, seen);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  crct_in_if  req_ch ();
  crct_out_if res_ch ();

  change_record_coalescing_table_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (req_ch.sink),
    .out_chan_o (res_ch.source)
  );

  coalesce_board board;
  bit            no_idle;
  bit            long_stall;
  bit            long_taken;
  int            hold_off;
  int            quiet_cycles;
  int            total_errors;
  logic [PortKeyW-1:0] key_pool[8];

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Send one request beat; may idle before it.
  task automatic send(logic cmd, logic [1:0] c, logic [PortKeyW-1:0] k, logic [1:0] a);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.command <= cmd;
    req_ch.category <= c;
    req_ch.item_key <= k;
    req_ch.change_kind <= a;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    board.note_request(cmd, c, k, a);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off when asked.
  always @(posedge clk_i) begin
    if (long_stall && !long_taken) begin
      long_taken <= 1;
      hold_off <= 300;
      res_ch.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_ch.ready <= 0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      res_ch.ready <= 0;
      hold_off <= $urandom_range(0, 13);
    end else begin
      res_ch.ready <= 1;
    end
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    beat_t got;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind = rkind_e'(res_ch.result_kind);
        got.cat = res_ch.out_category;
        got.key = res_ch.out_key;
        got.act = res_ch.out_action;
        got.st = status_e'(res_ch.status);
        got.last = res_ch.last;
        board.check_beat(got);
      end
      if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0] c;
    logic [1:0] a;
    logic [PortKeyW-1:0] k;
    board = new();
    no_idle = 0;
    long_stall = 0;
    hold_off = 0;
    quiet_cycles = 0;
    rst_ni = 0;
    req_ch.valid = 0;
    req_ch.command = CMD_APPLY;
    req_ch.category = 0;
    req_ch.item_key = 0;
    req_ch.change_kind = ACT_ADD;
    res_ch.ready = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty flush, every merge pair, invalid codes, extremes.
    send(CMD_FLUSH, 0, 0, 0);
    send(CMD_APPLY, 0, '1, ACT_ADD);
    send(CMD_APPLY, 0, '1, ACT_ADD);
    send(CMD_APPLY, 0, '1, ACT_UPD);
    send(CMD_APPLY, 0, '1, ACT_DEL);
    send(CMD_APPLY, 1, 0, ACT_UPD);
    send(CMD_APPLY, 1, 0, ACT_ADD);
    send(CMD_APPLY, 1, 0, ACT_UPD);
    send(CMD_APPLY, 1, 0, ACT_DEL);
    send(CMD_APPLY, 2, 32'h8000_0001, ACT_DEL);
    send(CMD_APPLY, 2, 32'h8000_0001, ACT_UPD);
    send(CMD_APPLY, 2, 32'h8000_0001, ACT_DEL);
    send(CMD_APPLY, 2, 32'h8000_0001, ACT_ADD);
    send(CMD_APPLY, 2, 5, ACT_INVALID);
    send(CMD_APPLY, CatInvalid, 5, ACT_ADD);
    send(CMD_APPLY, 0, 32'h5555_aaaa, ACT_ADD);
    send(CMD_FLUSH, 3, '1, 3);

    // Fill the table past its depth while the receiver holds off.
    long_stall = 1;
    for (int i = 0; i < Depth + 2; i++)
      send(CMD_APPLY, 2'(i % 3), 32'hf000_0000 ^ (i * 32'h0101_0107), ACT_UPD);
    send(CMD_FLUSH, 0, 0, 0);
    drain();

    // Random: mostly changes on a small key pool so merges hit.
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    for (int n = 0; n < 57; n++) begin
      if (n == 40) begin
        drain();
        no_idle = 1;
      end
      c = ($urandom_range(0, 19) == 0) ? CatInvalid : 2'($urandom_range(0, 2));
      a = ($urandom_range(0, 19) == 0) ? ACT_INVALID : 2'($urandom_range(0, 2));
      k = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 11) == 0) send(CMD_FLUSH, c, k, a);
      else send(CMD_APPLY, c, k, a);
    end
    send(CMD_FLUSH, 0, 0, 0);
    drain();
    repeat (200) @(posedge clk_i);

    total_errors = board.errors + board.pending.size();
    if (total_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
